### hdl/sha256_stream_hasher_top_assert.svh
// ---------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions shared by the sha-256 hasher
// ---------------------------------------------------------------------------
package shs_pkg;

    typedef logic [31:0] t_word;
    typedef logic [5:0]  t_idx6;

    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned BYTE_BITS    = 8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam t_idx6      FILL_LAST  = 6'd63;
    localparam t_idx6      LEN_START  = 6'd56;
    localparam t_idx6      ROUND_LAST = 6'd63;

    localparam t_word IV_TABLE [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // source of the byte pushed into the block
    typedef enum logic [1:0] {
        BSEL_INPUT = 2'd0,
        BSEL_MARK  = 2'd1,
        BSEL_ZERO  = 2'd2,
        BSEL_LEN   = 2'd3
    } t_bsel;

    typedef struct packed {
        logic  push;
        t_bsel bsel;
        logic  bits_add;
        logic  load_vars;
        logic  round;
        t_idx6 rnd_idx;
        logic  update;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        t_idx6 fill;
        logic  out_busy;
    } t_sts;

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

### hdl/shs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_in_if
// input channel: one op and one message byte per transfer
// ---------------------------------------------------------------------------
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface
`default_nettype wire

### hdl/shs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_out_if
// output channel: one digest word per transfer
// ---------------------------------------------------------------------------
interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        word_last;

    modport source (output valid, output digest_word, output word_last, input ready);
    modport sink   (input valid, input digest_word, input word_last, output ready);
endinterface
`default_nettype wire

### hdl/shs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_datapath
// block window, message schedule, round logic, chain value and digest buffer
// ---------------------------------------------------------------------------
module shs_datapath
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic             o_word_last
);

    // 64-byte block as a shift line; the oldest word sits at the top
    logic [511:0] r_msg;
    t_idx6        r_fill;
    logic [63:0]  r_bits;
    t_word        r_chain [DIGEST_WORDS];
    t_word        r_var   [DIGEST_WORDS];
    t_word        r_dig   [DIGEST_WORDS];
    logic [3:0]   r_ocnt;

    logic [7:0] push_byte;
    t_word      w_cur;
    t_word      w_new;
    t_word      t1;
    t_word      t2;
    t_word      ch;
    t_word      maj;
    t_word      sum [DIGEST_WORDS];
    logic       out_xfer;

    always_comb begin
        case (i_cmd.bsel)
            BSEL_INPUT: push_byte = i_data_byte;
            BSEL_MARK:  push_byte = PAD_MARK;
            BSEL_ZERO:  push_byte = 8'h00;
            BSEL_LEN:   push_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
            default:    push_byte = 8'h00;
        endcase
    end

    // schedule: w[i] from w[i-16], w[i-15], w[i-7], w[i-2]
    assign w_cur = r_msg[511 -: 32];
    assign w_new = small_sigma1(r_msg[63 -: 32]) + r_msg[223 -: 32]
                 + small_sigma0(r_msg[479 -: 32]) + w_cur;

    assign ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
    assign maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
    assign t1  = r_var[7] + big_sigma1(r_var[4]) + ch + K_TABLE[i_cmd.rnd_idx] + w_cur;
    assign t2  = big_sigma0(r_var[0]) + maj;

    always_comb begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            sum[i] = r_chain[i] + r_var[i];
        end
    end

    assign out_xfer = o_out_valid && i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            r_ocnt <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_chain[i] <= IV_TABLE[i];
            end
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.emit) begin
                r_bits <= '0;
            end else if (i_cmd.bits_add) begin
                r_bits <= r_bits + 64'(BYTE_BITS);
            end
            if (i_cmd.update) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= i_cmd.emit ? IV_TABLE[i] : sum[i];
                end
            end
            if (i_cmd.emit) begin
                r_ocnt <= 4'(DIGEST_WORDS);
            end else if (out_xfer) begin
                r_ocnt <= r_ocnt - 4'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_msg <= {r_msg[503:0], push_byte};
        end else if (i_cmd.round) begin
            r_msg <= {r_msg[479:0], w_new};
        end
        if (i_cmd.load_vars) begin
            r_var <= r_chain;
        end else if (i_cmd.round) begin
            r_var[0] <= t1 + t2;
            r_var[1] <= r_var[0];
            r_var[2] <= r_var[1];
            r_var[3] <= r_var[2];
            r_var[4] <= r_var[3] + t1;
            r_var[5] <= r_var[4];
            r_var[6] <= r_var[5];
            r_var[7] <= r_var[6];
        end
        if (i_cmd.emit) begin
            r_dig <= sum;
        end else if (out_xfer) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
    end

    assign o_sts.fill     = r_fill;
    assign o_sts.out_busy = (r_ocnt != '0);
    assign o_out_valid    = (r_ocnt != '0);
    assign o_digest_word  = r_dig[0];
    assign o_word_last    = (r_ocnt == 4'd1);

endmodule
`default_nettype wire

### hdl/shs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_ctrl
// sequencer for byte loading, padding, rounds and chain update
// ---------------------------------------------------------------------------
module shs_ctrl
    import shs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_op,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

`include "sha256_stream_hasher_top_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PAD    = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_idx6  r_rcnt;
    t_idx6  n_rcnt;
    logic   r_fin;
    logic   n_fin;
    // length goes into a second padding block
    logic   r_two;
    logic   n_two;
    t_cmd   cmd;
    logic   in_ready;

    always_comb begin
        n_state  = r_state;
        n_rcnt   = r_rcnt;
        n_fin    = r_fin;
        n_two    = r_two;
        cmd      = '0;
        cmd.bsel = BSEL_INPUT;
        in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = !((i_in_op == OP_FINISH) && i_sts.out_busy);
                if (i_in_valid && in_ready) begin
                    cmd.push = 1'b1;
                    if (i_in_op == OP_APPEND) begin
                        cmd.bits_add = 1'b1;
                    end else begin
                        cmd.bsel = BSEL_MARK;
                        n_fin    = 1'b1;
                        n_two    = (i_sts.fill >= LEN_START);
                    end
                    if (i_sts.fill == FILL_LAST) begin
                        cmd.load_vars = 1'b1;
                        n_rcnt        = '0;
                        n_state       = ST_ROUND;
                    end else if (i_in_op == OP_FINISH) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                cmd.bsel = ((i_sts.fill >= LEN_START) && !r_two) ? BSEL_LEN : BSEL_ZERO;
                if (i_sts.fill == FILL_LAST) begin
                    cmd.load_vars = 1'b1;
                    n_rcnt        = '0;
                    n_state       = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round   = 1'b1;
                cmd.rnd_idx = r_rcnt;
                n_rcnt      = r_rcnt + 6'd1;
                if (r_rcnt == ROUND_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_two) begin
                    n_two   = 1'b0;
                    n_state = ST_PAD;
                end else begin
                    cmd.emit = 1'b1;
                    n_fin    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rcnt  <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rcnt  <= n_rcnt;
            r_fin   <= n_fin;
            r_two   <= n_two;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = in_ready;

    `SHS_ASSERT_NEXT(a_rounds_end, (r_state == ST_ROUND) && (r_rcnt == ROUND_LAST), r_state == ST_UPDATE, "compression did not stop after the last round")
    `SHS_ASSERT_NOW(a_load_on_wrap, cmd.load_vars, cmd.push && (i_sts.fill == FILL_LAST), "compression started without a full block")
    `SHS_ASSERT_NOW(a_emit_clean, cmd.emit, !i_sts.out_busy && (i_sts.fill == '0), "digest emitted over a busy buffer or partial block")
    `SHS_ASSERT_NEXT(a_finish_marks, (r_state == ST_IDLE) && i_in_valid && in_ready && (i_in_op == OP_FINISH), r_fin, "finish transfer not tracked")

endmodule
`default_nettype wire

### hdl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top
// streaming sha-256: bytes in, eight digest words out per message
// ---------------------------------------------------------------------------
//  port    dir  payload                         per transfer
//  i_in    in   op, data_byte                   append one byte or finish
//  o_out   out  digest_word, word_last          one digest word, H0 first
//
//  a byte is taken while the sequencer is idle; the 64th byte of a block starts 64
//  rounds of the shared round unit, then one chain update
//  finish: padding bytes go in one per cycle up to the block end, then one or
//  two compressions; the digest then drains from its own buffer
//  new message bytes are taken while the digest drains; a finish waits for it
//  synchronous active-low reset loads the initial hash words, no clearing pass
// ---------------------------------------------------------------------------
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    shs_in_if.sink      i_in,
    shs_out_if.source   o_out
);

    t_cmd cmd;
    t_sts sts;

    shs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_in.data_byte),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_digest_word (o_out.digest_word),
        .o_word_last   (o_out.word_last)
    );

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha-256 stream hasher testbench
// short directed messages, then random messages of short and block-edge
// lengths; a scoreboard hashes every accepted byte and checks each digest word
// ---------------------------------------------------------------------------
module testbench;
    import shs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 180;
    localparam int unsigned TAIL_CALM    = 40;
    localparam int unsigned DRAIN_WAIT   = 300;
    localparam int unsigned PRINT_CAP    = 40;

    localparam bit [0:7][31:0] HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_entry;

    class digest_scoreboard;
        bit [0:7][31:0]  chain;
        bit [0:63][7:0]  blk;
        bit [5:0]        fill;
        bit [63:0]       msg_bits;
        t_digest_entry   pending [$];
        int unsigned     mismatches;

        function new();
            chain      = HASH_INIT;
            blk        = '0;
            fill       = '0;
            msg_bits   = '0;
            mismatches = 0;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            bit [0:63][31:0] w;
            bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int i = 0; i < 64; i++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + ROUND_K[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void absorb_byte(bit [7:0] data);
            blk[fill] = data;
            fill      = fill + 6'd1;
            if (fill == 6'd0)
                compress_block();
        endfunction

        // called on every accepted input transfer
        function void note_input(logic op, logic [7:0] data);
            bit [63:0] len;
            t_digest_entry ent;
            if (op == OP_APPEND) begin
                absorb_byte(data);
                msg_bits += 64'd8;
            end else begin
                len = msg_bits;
                absorb_byte(8'h80);
                while (fill != 6'd56)
                    absorb_byte(8'h00);
                for (int k = 0; k < 8; k++)
                    absorb_byte(len[63 - 8*k -: 8]);
                for (int k = 0; k < 8; k++) begin
                    ent.word = chain[k];
                    ent.last = (k == 7);
                    pending.push_back(ent);
                end
                chain    = HASH_INIT;
                fill     = '0;
                msg_bits = '0;
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // called on every accepted output transfer
        task check_result(logic [31:0] word, logic last);
            t_digest_entry ent;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("digest word %h with nothing pending", word));
            end else begin
                ent = pending.pop_front();
                if (word !== ent.word)
                    report_mismatch($sformatf("digest word %h, want %h", word, ent.word));
                if (last !== ent.last)
                    report_mismatch($sformatf("word_last %b, want %b", last, ent.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    shs_in_if  in_if ();
    shs_out_if out_if ();

    sha256_stream_hasher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    digest_scoreboard sb = new;
    bit               tail_calm = 1'b0;
    int unsigned      sent_items = 0;
    int unsigned      cycles = 0;
    // zero until the random part of the run starts
    int unsigned      item_goal = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output checked first so a finish taken at the same edge cannot cover it
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.digest_word, out_if.word_last);
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_input(in_if.op, in_if.data_byte);
    end

    // receiver stalls in bursts, with calm stretches in between
    initial begin : sink_side
        int unsigned calm_left;
        calm_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_left != 0)
                calm_left--;
            else if ($urandom_range(0, 31) == 0)
                calm_left = $urandom_range(40, 200);
            if (!tail_calm && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    // entered at the edge of the previous transfer, returns at the edge of this one
    task automatic send_item(input logic op, input logic [7:0] data, input bit idle);
        if (item_goal != 0 && sent_items + TAIL_CALM >= item_goal)
            tail_calm = 1'b1;
        if (idle && !tail_calm && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.data_byte <= data;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_message(input int unsigned len, input bit idle);
        for (int unsigned i = 0; i < len; i++)
            send_item(OP_APPEND, 8'($urandom_range(0, 255)), idle);
        send_item(OP_FINISH, 8'($urandom_range(0, 255)), idle);
    endtask

    initial begin : stimulus
        int unsigned len;
        bit          idle;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.op        = OP_APPEND;
        in_if.data_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, then "abc"
        send_item(OP_FINISH, 8'h00, 1'b1);
        send_item(OP_APPEND, 8'h61, 1'b1);
        send_item(OP_APPEND, 8'h62, 1'b1);
        send_item(OP_APPEND, 8'h63, 1'b1);
        send_item(OP_FINISH, 8'hff, 1'b1);
        // finish right behind a finish, while the digest still drains
        send_item(OP_FINISH, 8'h5a, 1'b0);
        send_item(OP_APPEND, 8'h00, 1'b0);
        send_item(OP_APPEND, 8'hff, 1'b0);
        send_item(OP_APPEND, 8'h80, 1'b0);
        send_item(OP_APPEND, 8'h7f, 1'b0);
        send_item(OP_FINISH, 8'h00, 1'b0);

        item_goal = sent_items + RANDOM_ITEMS;
        while (sent_items < item_goal) begin
            idle = ($urandom_range(0, 2) != 0);
            // lengths around the padding and block edges now and then
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end else begin
                len = $urandom_range(0, 24);
            end
            // last message is cut so the run ends near the item goal
            if (sent_items + len + 1 > item_goal)
                len = item_goal - sent_items - 1;
            send_message(len, idle);
        end
        in_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sha256_stream_hasher_top.f
+incdir+hdl
hdl/shs_pkg.sv
hdl/shs_in_if.sv
hdl/shs_out_if.sv
hdl/shs_datapath.sv
hdl/shs_ctrl.sv
hdl/sha256_stream_hasher_top.sv
bench/testbench.sv
